### src/chmc_pkg.sv
package chmc_pkg;

  localparam int MAX_LINES_DEF = 1024;
  localparam int ADDR_BITS_DEF = 26;
  localparam int MAX_WAYS_DEF  = 16;

  localparam int LINE_OUT_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STAMP_W    = 32;
  localparam int LFSR_W     = 16;

  localparam logic [1:0] MAP_DIRECT   = 2'd0;
  localparam logic [1:0] MAP_SET      = 2'd1;
  localparam logic [1:0] MAP_FULL     = 2'd2;
  localparam logic [1:0] MAP_FULL_ALT = 2'd3;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_FIFO = 2'd2;
  localparam logic [1:0] POL_RAND = 2'd3;

  localparam logic [1:0] KIND_NONE       = 2'd0;
  localparam logic [1:0] KIND_COMPULSORY = 2'd1;
  localparam logic [1:0] KIND_CAPACITY   = 2'd2;
  localparam logic [1:0] KIND_CONFLICT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAPPING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic start;
    logic step;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic issue_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] v;
    logic fb;
    v  = (cur == '0) ? LFSR_W'(1) : cur;
    fb = v[15] ^ v[13] ^ v[12] ^ v[10];
    return {v[LFSR_W-2:0], fb};
  endfunction

endpackage

### src/chmc_ram.sv
module chmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/chmc_ctrl.sv
module chmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output chmc_pkg::dp_cmd_t cmd,
  input  chmc_pkg::dp_sts_t sts
);
  import chmc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.issue_done) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

### src/chmc_dp.sv
module chmc_dp #(
  parameter int MAX_LINES = chmc_pkg::MAX_LINES_DEF,
  parameter int ADDR_BITS = chmc_pkg::ADDR_BITS_DEF,
  parameter int MAX_WAYS  = chmc_pkg::MAX_WAYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chmc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ADDR_BITS-1:0]                in_address,
  input  chmc_pkg::dp_cmd_t                   cmd,
  output chmc_pkg::dp_sts_t                   sts,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [1:0]                          out_miss_kind,
  output logic [chmc_pkg::LINE_OUT_W-1:0]     out_line_used
);
  import chmc_pkg::*;

  localparam int LW = $clog2(MAX_LINES);
  localparam logic [4:0] LOGL5 = 5'($clog2(MAX_LINES));
  localparam logic [4:0] LOGW5 = 5'($clog2(MAX_WAYS));
  localparam int TW = ADDR_BITS + 1;

  logic [1:0]        map_r;
  logic [2:0]        off_r;
  logic [3:0]        lbits_r;
  logic [2:0]        wbits_r;
  logic [1:0]        pol_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [STAMP_W-1:0] aclk_r;

  logic [4:0]           lb_c, w0_c, w1_c, wb_c;
  logic [ADDR_BITS-1:0] shifted_c;
  logic [LW:0]          lines_c, ways_c;
  logic [LW-1:0]        lmask_c, wmask_c, smask_c, base_c, idx_c;
  logic [ADDR_BITS-1:0] tag_c;

  logic [ADDR_BITS-1:0] tag_r;
  logic [LW-1:0]        idx_r, base_r, lmask_r, wmask_r;
  logic [LW:0]          n_r, cnt_r;
  logic                 dm_r, sa_r;
  logic [1:0]           upol_r;
  logic [STAMP_W-1:0]   stime_r;

  logic [LW-1:0]        clr_r;
  logic                 pend_r;
  logic [LW-1:0]        pptr_r;
  logic [LW-1:0]        raddr;

  logic                 fhit_r, finv_r, idxv_r, bfirst_r;
  logic [LW-1:0]        hline_r, iline_r, bline_r;
  logic [STAMP_W-1:0]   hstamp_r, best_r;

  logic [TW-1:0]        tag_rdata, tag_wdata;
  logic [STAMP_W-1:0]   st_rdata, st_wdata;
  logic                 tag_we, st_we;
  logic [LW-1:0]        waddr;

  logic                 rd_vld, hit_here, better;
  logic [ADDR_BITS-1:0] rd_tag;

  logic                 res_hit, lfsr_adv;
  logic [1:0]           res_kind;
  logic [LW-1:0]        res_line;
  logic [LFSR_W-1:0]    rnd;
  logic [STAMP_W-1:0]   new_stamp;

  logic                 res_hit_r;
  logic [1:0]           res_kind_r;
  logic [LW-1:0]        res_line_r;
  logic                 out_valid_r, out_hit_r;
  logic [1:0]           out_kind_r;
  logic [LINE_OUT_W-1:0] out_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= MAP_DIRECT;
      off_r   <= 3'd4;
      lbits_r <= 4'd6;
      wbits_r <= 3'd1;
      pol_r   <= POL_LRU;
      lfsr_r  <= LFSR_W'(1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAPPING: map_r   <= cfg_data[1:0];
          CFG_OFFSET:  off_r   <= cfg_data[2:0];
          CFG_LINES:   lbits_r <= cfg_data[3:0];
          CFG_WAYS:    wbits_r <= cfg_data[2:0];
          CFG_POLICY:  pol_r   <= cfg_data[1:0];
          CFG_SEED:    lfsr_r  <= cfg_data[LFSR_W-1:0];
          default: ;
        endcase
      end else if (lfsr_adv) begin
        lfsr_r <= rnd;
      end
    end
  end

  always_comb begin
    lb_c      = ({1'b0, lbits_r} > LOGL5) ? LOGL5 : {1'b0, lbits_r};
    w0_c      = {2'b00, wbits_r};
    w1_c      = (w0_c > LOGW5) ? LOGW5 : w0_c;
    wb_c      = (w1_c > lb_c) ? lb_c : w1_c;
    shifted_c = in_address >> off_r;
    lines_c   = (LW + 1)'(1) << lb_c;
    ways_c    = (LW + 1)'(1) << wb_c;
    lmask_c   = LW'(lines_c - 1'b1);
    wmask_c   = LW'(ways_c - 1'b1);
    smask_c   = lmask_c >> wb_c;
    idx_c     = shifted_c[LW-1:0] & lmask_c;
    base_c    = (shifted_c[LW-1:0] & smask_c) << wb_c;
    if (map_r == MAP_DIRECT) begin
      tag_c = in_address >> (6'(off_r) + 6'(lb_c));
    end else if (map_r == MAP_SET) begin
      tag_c = in_address >> (6'(off_r) + 6'(lb_c - wb_c));
    end else begin
      tag_c = shifted_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aclk_r <= '0;
      clr_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_r <= clr_r + 1'b1;
      if (cmd.start) begin
        aclk_r <= aclk_r + 1'b1;
        cnt_r  <= '0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pend_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag_r   <= tag_c;
      idx_r   <= idx_c;
      base_r  <= (map_r == MAP_SET) ? base_c : '0;
      n_r     <= (map_r == MAP_SET) ? ways_c : lines_c;
      lmask_r <= lmask_c;
      wmask_r <= wmask_c;
      dm_r    <= (map_r == MAP_DIRECT);
      sa_r    <= (map_r == MAP_SET);
      upol_r  <= pol_r;
      stime_r <= aclk_r;
    end
    pptr_r <= raddr;
  end

  assign raddr = base_r + cnt_r[LW-1:0];

  always_comb begin
    rd_vld   = tag_rdata[ADDR_BITS];
    rd_tag   = tag_rdata[ADDR_BITS-1:0];
    hit_here = rd_vld && (rd_tag == tag_r) && (!dm_r || (pptr_r == idx_r));
    better   = (upol_r == POL_LFU) ? (best_r >= st_rdata) : (best_r > st_rdata);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fhit_r   <= 1'b0;
      finv_r   <= 1'b0;
      idxv_r   <= 1'b0;
      bfirst_r <= 1'b1;
    end else if (pend_r) begin
      if (!fhit_r && hit_here) begin
        fhit_r   <= 1'b1;
        hline_r  <= pptr_r;
        hstamp_r <= st_rdata;
      end
      if (!finv_r && !rd_vld) begin
        finv_r  <= 1'b1;
        iline_r <= pptr_r;
      end
      if (pptr_r == idx_r) idxv_r <= rd_vld;
      if (bfirst_r || better) begin
        best_r  <= st_rdata;
        bline_r <= pptr_r;
      end
      bfirst_r <= 1'b0;
    end
  end

  always_comb begin
    rnd       = lfsr_step(lfsr_r);
    lfsr_adv  = 1'b0;
    res_hit   = fhit_r;
    res_kind  = KIND_NONE;
    res_line  = hline_r;
    tag_we    = 1'b0;
    st_we     = 1'b0;
    new_stamp = (upol_r == POL_LFU) ? '0 : stime_r;
    if (dm_r) begin
      res_line = idx_r;
      if (!fhit_r) begin
        tag_we = 1'b1;
        if (!finv_r) res_kind = KIND_CAPACITY;
        else if (idxv_r) res_kind = KIND_CONFLICT;
        else res_kind = KIND_COMPULSORY;
      end
    end else if (sa_r) begin
      if (!fhit_r) begin
        tag_we = 1'b1;
        if (finv_r) begin
          res_kind = KIND_COMPULSORY;
          res_line = iline_r;
        end else begin
          res_kind = KIND_CAPACITY;
          lfsr_adv = cmd.commit;
          res_line = base_r + (rnd[LW-1:0] & wmask_r);
        end
      end
    end else begin
      if (fhit_r) begin
        if (upol_r == POL_LRU) begin
          st_we = 1'b1;
        end else if (upol_r == POL_LFU) begin
          st_we     = 1'b1;
          new_stamp = (hstamp_r == '1) ? hstamp_r : hstamp_r + 1'b1;
        end
      end else begin
        tag_we = 1'b1;
        st_we  = 1'b1;
        if (finv_r) begin
          res_kind = KIND_COMPULSORY;
          res_line = iline_r;
        end else begin
          res_kind = KIND_CAPACITY;
          if (upol_r == POL_RAND) begin
            lfsr_adv = cmd.commit;
            res_line = rnd[LW-1:0] & lmask_r;
          end else begin
            res_line = bline_r;
          end
        end
      end
    end
    if (cmd.clear_wr) begin
      waddr     = clr_r;
      tag_wdata = '0;
      st_wdata  = '0;
      tag_we    = 1'b1;
      st_we     = 1'b1;
    end else begin
      waddr     = res_line;
      tag_wdata = {1'b1, tag_r};
      st_wdata  = new_stamp;
      tag_we    = tag_we && cmd.commit;
      st_we     = st_we && cmd.commit;
    end
  end

  chmc_ram #(.WIDTH(TW), .DEPTH(MAX_LINES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (waddr),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  chmc_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_LINES)) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_hit_r  <= res_hit;
      res_kind_r <= res_kind;
      res_line_r <= res_line;
    end
    if (cmd.load_out) begin
      out_hit_r  <= res_hit_r;
      out_kind_r <= res_kind_r;
      out_line_r <= LINE_OUT_W'(res_line_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.clear_done = (clr_r == LW'(MAX_LINES - 1));
  assign sts.issue_done = (cnt_r == n_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_miss_kind = out_kind_r;
  assign out_line_used = out_line_r;

endmodule

### src/cache_hit_miss_classifier.sv
// For each accepted address beat the tag and stamp RAMs are scanned one line per
// cycle over N lines, N being the lines in use (direct or fully associative) or
// the ways per set (set associative); the result is then committed and loaded
// into the output register, and only then is a new address taken. After reset
// a clearing pass writes all MAX_LINES entries of both RAMs before the first beat.
module cache_hit_miss_classifier #(
  parameter int MAX_LINES = chmc_pkg::MAX_LINES_DEF,
  parameter int ADDR_BITS = chmc_pkg::ADDR_BITS_DEF,
  parameter int MAX_WAYS  = chmc_pkg::MAX_WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [chmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ADDR_BITS-1:0]            in_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [1:0]                      out_miss_kind,
  output logic [chmc_pkg::LINE_OUT_W-1:0] out_line_used
);
  import chmc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  chmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  chmc_dp #(
    .MAX_LINES (MAX_LINES),
    .ADDR_BITS (ADDR_BITS),
    .MAX_WAYS  (MAX_WAYS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_address    (in_address),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_miss_kind (out_miss_kind),
    .out_line_used (out_line_used)
  );

endmodule

### src/chmc_chk.sv
module chmc_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_hit,
  input logic [1:0]                      out_miss_kind,
  input logic [chmc_pkg::LINE_OUT_W-1:0] out_line_used
);
  import chmc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_miss_kind) && $stable(out_line_used))
    else $error("stalled result beat changed");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_miss_kind == KIND_NONE)
    else $error("hit reported with a miss kind");

  a_miss_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_miss_kind != KIND_NONE)
    else $error("miss reported without a kind");

  a_clear_stall: assert property (@(posedge clk)
    $past(!rst_n) |-> in_stall)
    else $error("address beat taken during the clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second address beat taken while one is in flight");

endmodule

bind cache_hit_miss_classifier chmc_chk u_chk (.*);
